[rtl/sample_set_statistics_top_defines.svh]
// ----------------------------------------------------------------------------
// sample set statistics assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SAMPLE_SET_STATISTICS_TOP_DEFINES_SVH
`define SAMPLE_SET_STATISTICS_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, muted during reset
`define SSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, muted during reset
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ssstat_pkg.sv]
// ----------------------------------------------------------------------------
// ssstat_pkg
// widths, step counts and controller/datapath bundles for the statistics block
// ----------------------------------------------------------------------------
package ssstat_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 24;
  localparam int FIELD_BITS  = 16;
  localparam int SUM_BITS    = 40;
  localparam int SQ_BITS     = 55;

  // restoring divider runs one quotient bit per step over the widest dividend
  localparam int DIV_STEPS   = SQ_BITS;
  // root unit retires one root bit per step, two radicand bits at a time
  localparam int ROOT_STEPS  = (SQ_BITS + 1) / 2;
  localparam int RAD_BITS    = 2 * ROOT_STEPS;
  localparam int ROOT_BITS   = ROOT_STEPS;
  localparam int REM_BITS    = ROOT_BITS + 2;
  localparam int STEP_BITS   = $clog2(DIV_STEPS);
  localparam int Q_BITS      = SAMPLE_BITS + 1;

  typedef struct packed {
    logic acc_en;
    logic div_load;
    logic div_step;
    logic mul_en;
    logic root_load;
    logic root_step;
    logic out_load;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

[rtl/ssstat_if.sv]
// ----------------------------------------------------------------------------
// ssstat stream interfaces
// valid/ready channels for samples in and statistics out
// ----------------------------------------------------------------------------
interface ssstat_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ssstat_pkg::SAMPLE_BITS-1:0] sample;
  logic                                   sample_present;
  logic                                   last;

  modport source (output valid, output sample, output sample_present, output last,
                  input ready);
  modport sink   (input valid, input sample, input sample_present, input last,
                  output ready);
endinterface

interface ssstat_out_if;
  logic                                     valid;
  logic                                     ready;
  logic        [ssstat_pkg::COUNT_BITS-1:0] count;
  logic signed [ssstat_pkg::FIELD_BITS-1:0] mean;
  logic        [ssstat_pkg::FIELD_BITS-1:0] deviation;
  logic signed [ssstat_pkg::FIELD_BITS-1:0] maximum;
  logic signed [ssstat_pkg::FIELD_BITS-1:0] minimum;
  logic                                     overflow;

  modport source (output valid, output count, output mean, output deviation,
                  output maximum, output minimum, output overflow, input ready);
  modport sink   (input valid, input count, input mean, input deviation,
                  input maximum, input minimum, input overflow, output ready);
endinterface

[rtl/ssstat_ctrl.sv]
// ----------------------------------------------------------------------------
// ssstat_ctrl
// sequencer: accumulate, divide, square, root, then hand the result over
// ----------------------------------------------------------------------------
module ssstat_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  input  ssstat_pkg::sts_t   sts_i,
  output logic               in_ready_o,
  output ssstat_pkg::cmd_t   cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDload = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StRload = 3'd4;
  localparam logic [2:0] StRoot  = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  localparam int SB = ssstat_pkg::STEP_BITS;

  logic [2:0]    state_q, state_d;
  logic [SB-1:0] cnt_q, cnt_d;
  logic          accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.acc_en = accept;
    case (state_q)
      StIdle: begin
        if (accept && in_last_i) state_d = StDload;
      end
      StDload: begin
        cmd_o.div_load = 1'b1;
        cnt_d   = SB'(ssstat_pkg::DIV_STEPS - 1);
        state_d = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) state_d = StMul;
        else cnt_d = cnt_q - SB'(1);
      end
      StMul: begin
        cmd_o.mul_en = 1'b1;
        state_d = StRload;
      end
      StRload: begin
        cmd_o.root_load = 1'b1;
        cnt_d   = SB'(ssstat_pkg::ROOT_STEPS - 1);
        state_d = StRoot;
      end
      StRoot: begin
        cmd_o.root_step = 1'b1;
        if (cnt_q == '0) state_d = StDone;
        else cnt_d = cnt_q - SB'(1);
      end
      StDone: begin
        // wait for the output register to free up
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          cmd_o.clear    = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/ssstat_dp.sv]
// ----------------------------------------------------------------------------
// ssstat_dp
// accumulators, bit-serial divider pair, squarer, bit-serial root, output reg
// ----------------------------------------------------------------------------
module ssstat_dp (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  ssstat_pkg::cmd_t                         cmd_i,
  output ssstat_pkg::sts_t                         sts_o,
  input  logic signed [ssstat_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                     sample_present_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic        [ssstat_pkg::COUNT_BITS-1:0] count_o,
  output logic signed [ssstat_pkg::FIELD_BITS-1:0] mean_o,
  output logic        [ssstat_pkg::FIELD_BITS-1:0] deviation_o,
  output logic signed [ssstat_pkg::FIELD_BITS-1:0] maximum_o,
  output logic signed [ssstat_pkg::FIELD_BITS-1:0] minimum_o,
  output logic                                     overflow_o
);

  localparam int SB  = ssstat_pkg::SAMPLE_BITS;
  localparam int CB  = ssstat_pkg::COUNT_BITS;
  localparam int FB  = ssstat_pkg::FIELD_BITS;
  localparam int UB  = ssstat_pkg::SUM_BITS;
  localparam int QB  = ssstat_pkg::SQ_BITS;
  localparam int NB  = ssstat_pkg::Q_BITS;
  localparam int RDB = ssstat_pkg::RAD_BITS;
  localparam int RTB = ssstat_pkg::ROOT_BITS;
  localparam int RMB = ssstat_pkg::REM_BITS;

  // set accumulators
  logic [CB-1:0]        cnt_q;
  logic [UB-1:0]        sum_q;
  logic [QB-1:0]        sq_q;
  logic signed [SB-1:0] max_q, min_q;
  logic                 drop_q;

  // divider pair: sumsq / n and |sum| / n share the divisor and the steps
  logic [QB-1:0]        da_x_q, dm_x_q;
  logic [CB-1:0]        da_r_q, dm_r_q;
  logic                 neg_q;
  logic [2*NB-1:0]      msq_q;

  // root unit
  logic [RDB-1:0]       rt_x_q;
  logic [RTB-1:0]       rt_y_q;
  logic [RMB-1:0]       rt_r_q;

  // output register
  logic                 ov_q;
  logic [CB-1:0]        o_cnt_q;
  logic [FB-1:0]        o_mean_q, o_dev_q, o_max_q, o_min_q;
  logic                 o_ovf_q;

  logic                  full;
  logic signed [2*SB-1:0] s_sq;
  logic [UB-1:0]         mag;
  logic [CB:0]           da_sh, dm_sh;
  logic                  da_ge, dm_ge;
  logic [QB-1:0]         msq_ext, rad;
  logic [RMB+1:0]        rt_sh, rt_trial;
  logic                  rt_ge;
  logic [FB-1:0]         q_low, dev_sat;
  logic                  empty;

  assign full  = (cnt_q == {CB{1'b1}});
  assign s_sq  = sample_i * sample_i;
  assign mag   = sum_q[UB-1] ? (~sum_q + UB'(1)) : sum_q;

  assign da_sh = {da_r_q, da_x_q[QB-1]};
  assign dm_sh = {dm_r_q, dm_x_q[QB-1]};
  assign da_ge = (da_sh >= {1'b0, cnt_q});
  assign dm_ge = (dm_sh >= {1'b0, cnt_q});

  assign msq_ext = {{(QB - 2*NB){1'b0}}, msq_q};
  assign rad     = (da_x_q > msq_ext) ? (da_x_q - msq_ext) : '0;

  assign rt_sh    = {rt_r_q, rt_x_q[RDB-1 -: 2]};
  assign rt_trial = {2'b00, rt_y_q, 2'b01};
  assign rt_ge    = (rt_sh >= rt_trial);

  assign q_low   = dm_x_q[FB-1:0];
  assign dev_sat = (rt_y_q[RTB-1:FB] != '0) ? {FB{1'b1}} : rt_y_q[FB-1:0];
  assign empty   = (cnt_q == '0);

  // accumulation and set clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      max_q  <= '0;
      min_q  <= '0;
      drop_q <= 1'b0;
    end else if (cmd_i.clear) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      max_q  <= '0;
      min_q  <= '0;
      drop_q <= 1'b0;
    end else if (cmd_i.acc_en && sample_present_i) begin
      if (full) begin
        drop_q <= 1'b1;
      end else begin
        if (empty || sample_i > max_q) max_q <= sample_i;
        if (empty || sample_i < min_q) min_q <= sample_i;
        cnt_q <= cnt_q + CB'(1);
        sum_q <= sum_q + {{(UB - SB){sample_i[SB-1]}}, sample_i};
        sq_q  <= sq_q + {{(QB - 2*SB){1'b0}}, s_sq};
      end
    end
  end

  // divide, square, root
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      da_x_q <= sq_q;
      dm_x_q <= {{(QB - UB){1'b0}}, mag};
      da_r_q <= '0;
      dm_r_q <= '0;
      neg_q  <= sum_q[UB-1];
    end else if (cmd_i.div_step) begin
      da_r_q <= da_ge ? CB'(da_sh - {1'b0, cnt_q}) : da_sh[CB-1:0];
      dm_r_q <= dm_ge ? CB'(dm_sh - {1'b0, cnt_q}) : dm_sh[CB-1:0];
      da_x_q <= {da_x_q[QB-2:0], da_ge};
      dm_x_q <= {dm_x_q[QB-2:0], dm_ge};
    end
    if (cmd_i.mul_en) begin
      msq_q <= dm_x_q[NB-1:0] * dm_x_q[NB-1:0];
    end
    if (cmd_i.root_load) begin
      rt_x_q <= {{(RDB - QB){1'b0}}, rad};
      rt_y_q <= '0;
      rt_r_q <= '0;
    end else if (cmd_i.root_step) begin
      rt_x_q <= {rt_x_q[RDB-3:0], 2'b00};
      rt_r_q <= rt_ge ? RMB'(rt_sh - rt_trial) : rt_sh[RMB-1:0];
      rt_y_q <= {rt_y_q[RTB-2:0], rt_ge};
    end
  end

  // result register, freed by an output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      o_cnt_q  <= cnt_q;
      o_mean_q <= empty ? '0 : (neg_q ? (~q_low + FB'(1)) : q_low);
      o_dev_q  <= empty ? '0 : dev_sat;
      o_max_q  <= empty ? '0 : max_q;
      o_min_q  <= empty ? '0 : min_q;
      o_ovf_q  <= drop_q;
    end
  end

  assign sts_o.out_busy = ov_q & ~out_ready_i;
  assign out_valid_o    = ov_q;
  assign count_o        = o_cnt_q;
  assign mean_o         = o_mean_q;
  assign deviation_o    = o_dev_q;
  assign maximum_o      = o_max_q;
  assign minimum_o      = o_min_q;
  assign overflow_o     = o_ovf_q;

endmodule

[rtl/sample_set_statistics_top.sv]
// ----------------------------------------------------------------------------
// sample_set_statistics_top
// input: transfers without last are absorbed at one transfer per cycle while idle
// closing: a closing (last) transfer starts the compute phase; no input is taken
//   until the result is loaded: 55-step restoring divider plus 28-step root unit
// next input: taken once the result is loaded, which is later while
//   the previous result still waits for its output transfer
// reset: rst_ni clears the running set and the output valid at once
// ----------------------------------------------------------------------------
module sample_set_statistics_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  ssstat_in_if.sink      in_i,
  ssstat_out_if.source   out_o
);

  ssstat_pkg::cmd_t cmd;
  ssstat_pkg::sts_t sts;
  logic             in_ready;

  ssstat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  ssstat_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .sample_i         (in_i.sample),
    .sample_present_i (in_i.sample_present),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .count_o          (out_o.count),
    .mean_o           (out_o.mean),
    .deviation_o      (out_o.deviation),
    .maximum_o        (out_o.maximum),
    .minimum_o        (out_o.minimum),
    .overflow_o       (out_o.overflow)
  );

  assign in_i.ready = in_ready;

endmodule

[rtl/ssstat_chk.sv]
// ----------------------------------------------------------------------------
// ssstat_chk
// port-level checks on the statistics block, bound to the top level
// ----------------------------------------------------------------------------
`include "sample_set_statistics_top_defines.svh"

module ssstat_chk (
  input logic                                     clk_i,
  input logic                                     rst_ni,
  input logic                                     in_valid_i,
  input logic                                     in_ready_i,
  input logic                                     in_last_i,
  input logic                                     out_valid_i,
  input logic                                     out_ready_i,
  input logic        [ssstat_pkg::COUNT_BITS-1:0] count_i,
  input logic signed [ssstat_pkg::FIELD_BITS-1:0] mean_i,
  input logic        [ssstat_pkg::FIELD_BITS-1:0] deviation_i,
  input logic signed [ssstat_pkg::FIELD_BITS-1:0] maximum_i,
  input logic signed [ssstat_pkg::FIELD_BITS-1:0] minimum_i,
  input logic                                     overflow_i
);

  logic out_stall;
  logic in_close;
  logic stats_zero;
  logic mean_bounded;

  assign out_stall    = out_valid_i && !out_ready_i;
  assign in_close     = in_valid_i && in_ready_i && in_last_i;
  assign stats_zero   = (mean_i == '0) && (deviation_i == '0) &&
                        (maximum_i == '0) && (minimum_i == '0);
  assign mean_bounded = (minimum_i <= mean_i) && (mean_i <= maximum_i);

  // a stalled result keeps its count
  `SSS_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i && $stable(count_i), "stalled result changed")

  // closing a set always blocks input for the compute phase
  `SSS_ASSERT_NEXT(a_close_blocks, in_close, !in_ready_i, "input taken during compute")

  // an empty set reports zeros
  `SSS_ASSERT_NOW(a_empty_zero, out_valid_i && count_i == '0, stats_zero, "empty set not zero")

  // the mean lies between the extremes
  `SSS_ASSERT_NOW(a_mean_range, out_valid_i && count_i != '0, mean_bounded, "mean outside extremes")

  // dropping only happens on a saturated count
  `SSS_ASSERT_NOW(a_ovf_full, out_valid_i && overflow_i, count_i == '1, "overflow without full count")

endmodule

bind sample_set_statistics_top ssstat_chk u_ssstat_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .count_i     (out_o.count),
  .mean_i      (out_o.mean),
  .deviation_i (out_o.deviation),
  .maximum_i   (out_o.maximum),
  .minimum_i   (out_o.minimum),
  .overflow_i  (out_o.overflow)
);

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_set_statistics_top testbench
// drives sample sets through the input channel at random pace, predicts
// count, mean, deviation and extremes per closed set and checks every
// result transfer against the oldest prediction
// ----------------------------------------------------------------------------
module tb;

  localparam int SAMPLE_BITS = ssstat_pkg::SAMPLE_BITS;
  localparam int COUNT_BITS  = ssstat_pkg::COUNT_BITS;
  localparam int FIELD_BITS  = ssstat_pkg::FIELD_BITS;
  localparam int SUM_BITS    = ssstat_pkg::SUM_BITS;
  localparam int SQ_BITS     = ssstat_pkg::SQ_BITS;

  localparam int RANDOM_ITEMS   = 1750;
  localparam int IDLE_PERCENT   = 27;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int DIRECTED_ROWS  = 22;

  typedef struct packed {
    logic        [COUNT_BITS-1:0] count;
    logic signed [FIELD_BITS-1:0] mean;
    logic        [FIELD_BITS-1:0] deviation;
    logic signed [FIELD_BITS-1:0] maximum;
    logic signed [FIELD_BITS-1:0] minimum;
    logic                         overflow;
  } stats_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          present;
    logic                          last;
    logic                          typed;
    stats_t                        stats;
  } stim_row_t;

  localparam stats_t NO_STATS = '0;

  logic clk = 1'b0;
  logic rst_n;

  ssstat_in_if  in_ch ();
  ssstat_out_if out_ch ();

  sample_set_statistics_top u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #4 clk = ~clk;

  // predictor state for the open set
  logic        [COUNT_BITS-1:0]  set_count;
  logic signed [SUM_BITS-1:0]    set_sum;
  logic        [SQ_BITS-1:0]     set_sq_sum;
  logic signed [SAMPLE_BITS-1:0] set_max;
  logic signed [SAMPLE_BITS-1:0] set_min;
  logic                          set_dropped;

  stats_t stats_due[$];
  int     errors = 0;
  bit     tx_idle_on = 1'b1;
  bit     rx_idle_on = 1'b1;
  bit     hold_req = 1'b0;

  // directed sets: empty sets, extremes, truncation, bare markers, noise
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{16'sh7FFF, 1'b0, 1'b1, 1'b1, '{24'd0, 16'sd0, 16'd0, 16'sd0, 16'sd0, 1'b0}},
    '{16'sh5A5A, 1'b0, 1'b0, 1'b0, NO_STATS},
    '{16'sd32767, 1'b1, 1'b1, 1'b1,
      '{24'd1, 16'sd32767, 16'd0, 16'sd32767, 16'sd32767, 1'b0}},
    '{-16'sd32768, 1'b1, 1'b1, 1'b1,
      '{24'd1, -16'sd32768, 16'd0, -16'sd32768, -16'sd32768, 1'b0}},
    '{16'sd0, 1'b1, 1'b1, 1'b1, '{24'd1, 16'sd0, 16'd0, 16'sd0, 16'sd0, 1'b0}},
    '{-16'sd1, 1'b1, 1'b1, 1'b1, '{24'd1, -16'sd1, 16'd0, -16'sd1, -16'sd1, 1'b0}},
    '{16'sd32767, 1'b1, 1'b0, 1'b0, NO_STATS},
    '{-16'sd32768, 1'b1, 1'b0, 1'b0, NO_STATS},
    '{-16'sd32768, 1'b0, 1'b1, 1'b0, NO_STATS},
    '{-16'sd3, 1'b1, 1'b0, 1'b0, NO_STATS},
    '{-16'sd4, 1'b1, 1'b1, 1'b0, NO_STATS},
    '{-16'sd100, 1'b1, 1'b0, 1'b0, NO_STATS},
    '{16'sh2AAA, 1'b0, 1'b0, 1'b0, NO_STATS},
    '{-16'sd200, 1'b1, 1'b0, 1'b0, NO_STATS},
    '{16'sd50, 1'b1, 1'b1, 1'b0, NO_STATS},
    '{-16'sd32768, 1'b1, 1'b0, 1'b0, NO_STATS},
    '{-16'sd32768, 1'b1, 1'b0, 1'b0, NO_STATS},
    '{-16'sd32768, 1'b1, 1'b0, 1'b0, NO_STATS},
    '{-16'sd32768, 1'b1, 1'b1, 1'b1,
      '{24'd4, -16'sd32768, 16'd0, -16'sd32768, -16'sd32768, 1'b0}},
    '{16'sd32767, 1'b1, 1'b0, 1'b0, NO_STATS},
    '{16'sd32767, 1'b1, 1'b1, 1'b1,
      '{24'd2, 16'sd32767, 16'd0, 16'sd32767, 16'sd32767, 1'b0}},
    '{16'sd0, 1'b0, 1'b1, 1'b1, '{24'd0, 16'sd0, 16'd0, 16'sd0, 16'sd0, 1'b0}}
  };

  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned r;
    longint unsigned cand;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (cand * cand <= x) r = cand;
    end
    return r;
  endfunction

  function automatic void clear_set();
    set_count   = '0;
    set_sum     = '0;
    set_sq_sum  = '0;
    set_max     = '0;
    set_min     = '0;
    set_dropped = 1'b0;
  endfunction

  // advance the predictor by one accepted transfer
  function automatic void absorb_transfer(input logic signed [SAMPLE_BITS-1:0] smp,
                                          input logic present, input logic last_flag,
                                          output bit emitted, output stats_t res);
    logic            [SUM_BITS-1:0] mag;
    longint unsigned q, msq, avg_sq, spread, root;
    logic                           neg;
    emitted = 1'b0;
    res     = '0;
    if (present) begin
      if (set_count == '1) begin
        set_dropped = 1'b1;
      end else begin
        if (set_count == 0 || smp > set_max) set_max = smp;
        if (set_count == 0 || smp < set_min) set_min = smp;
        set_count  = set_count + 1'b1;
        set_sum    = set_sum + SUM_BITS'(smp);
        set_sq_sum = set_sq_sum + SQ_BITS'(longint'(smp) * longint'(smp));
      end
    end
    if (last_flag) begin
      emitted      = 1'b1;
      res.count    = set_count;
      res.overflow = set_dropped;
      if (set_count != 0) begin
        neg    = set_sum[SUM_BITS-1];
        mag    = neg ? SUM_BITS'(-set_sum) : SUM_BITS'(set_sum);
        q      = 64'(mag) / 64'(set_count);
        msq    = q * q;
        avg_sq = 64'(set_sq_sum) / 64'(set_count);
        spread = (avg_sq > msq) ? avg_sq - msq : 64'd0;
        root   = floor_root(spread);
        res.mean      = neg ? FIELD_BITS'(-q) : FIELD_BITS'(q);
        res.deviation = (root > 64'hFFFF) ? 16'hFFFF : FIELD_BITS'(root);
        res.maximum   = set_max;
        res.minimum   = set_min;
      end
      clear_set();
    end
  endfunction

  task automatic send_item(input logic signed [SAMPLE_BITS-1:0] smp, input logic present,
                           input logic last_flag, input logic typed,
                           input stats_t typed_stats);
    stats_t predicted;
    bit     emitted;
    @(negedge clk);
    while (tx_idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.sample         <= smp;
    in_ch.sample_present <= present;
    in_ch.last           <= last_flag;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb_transfer(smp, present, last_flag, emitted, predicted);
    if (emitted) stats_due.push_back(typed ? typed_stats : predicted);
  endtask

  task automatic go_quiet_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sd32767;
      1:       return -16'sd32768;
      2:       return SAMPLE_BITS'($signed($urandom_range(0, 16)) - 8);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic report_field(input string name, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    errors++;
  endtask

  // result side: random ready, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ch.ready <= !(rx_idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
      end
    end
  end

  always @(posedge clk) begin
    stats_t want;
    stats_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.count     = out_ch.count;
      got.mean      = out_ch.mean;
      got.deviation = out_ch.deviation;
      got.maximum   = out_ch.maximum;
      got.minimum   = out_ch.minimum;
      got.overflow  = out_ch.overflow;
      if (stats_due.size() == 0) begin
        $display("%0t: result transfer with nothing expected, got count %0d mean %0d",
                 $time, got.count, got.mean);
        errors++;
      end else begin
        want = stats_due.pop_front();
        if (got.count !== want.count) report_field("count", want.count, got.count);
        if (got.mean !== want.mean) report_field("mean", want.mean, got.mean);
        if (got.deviation !== want.deviation)
          report_field("deviation", want.deviation, got.deviation);
        if (got.maximum !== want.maximum)
          report_field("maximum", want.maximum, got.maximum);
        if (got.minimum !== want.minimum)
          report_field("minimum", want.minimum, got.minimum);
        if (got.overflow !== want.overflow)
          report_field("overflow", want.overflow, got.overflow);
      end
    end
  end

  // stall detector: no transfer on either side for too long
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("sample_set_statistics_top verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int sent;
    int len;
    int r;
    bit bare_close;
    bit closing;
    bit hold_done;
    bit pause_done;
    sent       = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.sample         = '0;
    in_ch.sample_present = 1'b0;
    in_ch.last           = 1'b0;
    clear_set();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_item(directed_rows[i].smp, directed_rows[i].present, directed_rows[i].last,
                directed_rows[i].typed, directed_rows[i].stats);
    go_quiet_until_drained();

    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 6)       len = 0;
      else if (r < 86) len = $urandom_range(1, 16);
      else if (r < 97) len = $urandom_range(17, 120);
      else             len = $urandom_range(121, 400);
      bare_close = (len == 0) || ($urandom_range(0, 2) == 0);
      for (int i = 0; i < len; i++) begin
        // stray transfers that carry neither a sample nor an end marker
        if ($urandom_range(0, 99) < 8) begin
          send_item(SAMPLE_BITS'($urandom), 1'b0, 1'b0, 1'b0, NO_STATS);
          sent++;
        end
        closing = !bare_close && (i == len - 1);
        send_item(pick_sample(), 1'b1, closing, 1'b0, NO_STATS);
        sent++;
      end
      if (bare_close) begin
        send_item(SAMPLE_BITS'($urandom), 1'b0, 1'b1, 1'b0, NO_STATS);
        sent++;
      end
      if (sent >= 300 && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      tx_idle_on = !(sent >= 600 && sent < 1000);
      rx_idle_on = tx_idle_on;
      if (sent >= 1200 && !pause_done) begin
        pause_done = 1'b1;
        go_quiet_until_drained();
      end
    end

    go_quiet_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("sample_set_statistics_top verification clean");
    end else begin
      $display("sample_set_statistics_top verification failed");
    end
    $finish;
  end

endmodule
